@@ design/uiv_pkg.sv @@
// Shared types and constants for the UTF-8 identifier validator.
package uiv_pkg;

   // Field widths.
   localparam int DATA_W       = 8;
   localparam int MAX_ID_W     = 16;
   localparam int COUNT_W      = 17;
   localparam int CP_W         = 21;
   localparam int STATUS_W     = 3;
   localparam int KIND_W       = 3;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int RSP_DATA_W   = 24;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register map, selected by address bit 2.
   localparam logic REG_MAX_ID_BYTES = 1'b0;
   localparam logic [MAX_ID_W-1:0] MAX_ID_BYTES_RESET = 16'd4096;

   // Result status codes; the recorded error uses the same codes.
   localparam logic [STATUS_W-1:0] STATUS_PROGRESS = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_CONTROL  = 3'd5;

   // Byte classes found by the front.
   localparam logic [KIND_W-1:0] KIND_ASCII = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LEAD2 = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LEAD3 = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEAD4 = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CONT  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BAD   = 3'd5;

   // Code point limits.
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'h1FFFF;
   localparam logic [CP_W-1:0]    CP_MAX       = 21'h10FFFF;
   localparam logic [CP_W-1:0]    SURR_LOW     = 21'h00D800;
   localparam logic [CP_W-1:0]    SURR_HIGH    = 21'h00DFFF;
   localparam logic [CP_W-1:0]    MIN_TWO      = 21'h000080;
   localparam logic [CP_W-1:0]    MIN_THREE    = 21'h000800;
   localparam logic [CP_W-1:0]    MIN_FOUR     = 21'h010000;
   localparam logic [CP_W-1:0]    C0_HIGH      = 21'h00001F;
   localparam logic [CP_W-1:0]    C1_LOW       = 21'h00007F;
   localparam logic [CP_W-1:0]    C1_HIGH      = 21'h00009F;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
      logic              no_byte;
      logic [KIND_W-1:0] byte_kind;
   } item_type;

   // Handshake between the queue and the back.
   typedef struct packed {
      logic valid;
      logic pop;
   } queue_ctl_type;

endpackage

@@ design/utf8_identifier_validator_top.sv @@
// Top level of the UTF-8 identifier validator: front, queue, back and register port.

// The validator takes an identifier one byte per transfer on the req_ channel
// (req_tlast ends the identifier, req_tuser marks a transfer with no byte) and
// gives exactly one result transfer per input transfer on the rsp_ channel.
// It sustains one byte per clock cycle while the receiver keeps up: the back
// decodes a byte at a time, and that per-byte decode state loop sets the rate.
// Each accepted byte goes into the queue; when the back pops it, its result is
// registered and offered from the result register. A small queue between the
// byte classifier and the decoder, plus the result register, lets either side
// stall without stopping the other. The length limit max_id_bytes sits at byte
// address 0 of the register port and resets to 4096; write it only while idle.
module utf8_identifier_validator_top import uiv_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   input  logic                  req_tuser,   // no_byte
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] status, [23:3] char_value
   output logic                  rsp_tlast,   // id_done
   output logic                  rsp_tuser,   // char_done
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [MAX_ID_W-1:0] max_id_ff, max_id_in;
   logic                csr_write;
   logic                queue_full;
   logic                push;
   item_type            push_item;
   item_type            pop_item;
   logic                pop_valid;
   queue_ctl_type       queue_ctl;

   // Register port: always ready, written in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign max_id_in  = (csr_write && csr_paddr[2] == REG_MAX_ID_BYTES) ?
                       csr_pwdata[MAX_ID_W-1:0] : max_id_ff;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_ID_BYTES) ?
                       CSR_DATA_W'(max_id_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_id_ff <= MAX_ID_BYTES_RESET;
      end else begin
         max_id_ff <= max_id_in;
      end
   end

   uiv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   uiv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_ctl.pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   uiv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item         (pop_item),
      .item_valid   (pop_valid),
      .queue_ctl    (queue_ctl),
      .max_id_bytes (max_id_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

   // A decoded code point is never a surrogate, a control or above the range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[23:3] <= CP_MAX) &&
         !(rsp_tdata[23:3] >= SURR_LOW && rsp_tdata[23:3] <= SURR_HIGH) &&
         (rsp_tdata[23:3] > C0_HIGH) &&
         !(rsp_tdata[23:3] >= C1_LOW && rsp_tdata[23:3] <= C1_HIGH))
      else $error("decoded code point out of the legal set");

   // A final status is given exactly on the result that ends the identifier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[2:0] != STATUS_PROGRESS)))
      else $error("status does not match id_done");

   // No code point is reported without its flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:3] == '0))
      else $error("code point given without char_done");

   // The back never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      queue_ctl.pop |-> queue_ctl.valid)
      else $error("pop from an empty queue");

endmodule

@@ design/uiv_front.sv @@
// Front: accepts input transfers and classifies each byte by its UTF-8 role.
module uiv_front import uiv_pkg::*; (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,    // data_byte
   input  logic              req_tlast,
   input  logic              req_tuser,    // no_byte
   input  logic              queue_full,
   output logic              push,
   output item_type          item
);

   logic [KIND_W-1:0] kind;

   // Classify the byte from its high-order bits.
   always_comb begin
      if (req_tdata[7] == 1'b0) begin
         kind = KIND_ASCII;
      end else if (req_tdata[7:6] == 2'b10) begin
         kind = KIND_CONT;
      end else if (req_tdata[7:5] == 3'b110) begin
         kind = KIND_LEAD2;
      end else if (req_tdata[7:4] == 4'b1110) begin
         kind = KIND_LEAD3;
      end else if (req_tdata[7:3] == 5'b11110) begin
         kind = KIND_LEAD4;
      end else begin
         kind = KIND_BAD;
      end
   end

   // Accept whenever the queue has room.
   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;

   assign item.data_byte = req_tdata;
   assign item.last_byte = req_tlast;
   assign item.no_byte   = req_tuser;
   assign item.byte_kind = kind;

endmodule

@@ design/uiv_queue.sv @@
// Short queue of classified bytes between the front and the back.
module uiv_queue import uiv_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slot_ff [DEPTH];
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;
   logic                 do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop & pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/uiv_back.sv @@
// Back: runs the UTF-8 decode state per byte and holds the result register.
module uiv_back import uiv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  item_type              item,
   input  logic                  item_valid,
   output queue_ctl_type         queue_ctl,
   input  logic [MAX_ID_W-1:0]   max_id_bytes,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic [COUNT_W-1:0]  count_ff,  count_in;
   logic [1:0]          pend_ff,   pend_in;
   logic [2:0]          seq_ff,    seq_in;
   logic [CP_W-1:0]     part_ff,   part_in;
   logic [STATUS_W-1:0] err_ff,    err_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff,    status_in;
   logic                char_ff,      char_in;
   logic                done_ff,      done_in;
   logic [CP_W-1:0]     cp_ff,        cp_in;

   logic                pop;
   logic                check;
   logic                got;
   logic [CP_W-1:0]     value;
   logic [CP_W-1:0]     shifted;
   logic [CP_W-1:0]     minimum;
   logic [STATUS_W-1:0] final_err;
   logic [STATUS_W-1:0] status;

   // Take the next item when the result register is free or being emptied.
   assign pop           = item_valid & (~rsp_valid_ff | rsp_tready);
   assign queue_ctl.valid = item_valid;
   assign queue_ctl.pop   = pop;

   assign shifted = {part_ff[CP_W-7:0], item.data_byte[5:0]};

   // Smallest legal value for the sequence length, to reject overlong forms.
   always_comb begin
      case (seq_ff)
         3'd2:    minimum = MIN_TWO;
         3'd3:    minimum = MIN_THREE;
         default: minimum = MIN_FOUR;
      endcase
   end

   // Decode step for one item.
   always_comb begin
      count_in  = count_ff;
      pend_in   = pend_ff;
      seq_in    = seq_ff;
      part_in   = part_ff;
      err_in    = err_ff;
      check     = 1'b0;
      got       = 1'b0;
      value     = '0;
      final_err = STATUS_PROGRESS;
      status    = STATUS_PROGRESS;
      if (!item.no_byte) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (err_ff == STATUS_PROGRESS) begin
            if (pend_ff == 2'd0) begin
               case (item.byte_kind)
                  KIND_ASCII: begin
                     value = CP_W'(item.data_byte);
                     check = 1'b1;
                  end
                  KIND_LEAD2: begin
                     seq_in  = 3'd2;
                     pend_in = 2'd1;
                     part_in = CP_W'(item.data_byte[4:0]);
                  end
                  KIND_LEAD3: begin
                     seq_in  = 3'd3;
                     pend_in = 2'd2;
                     part_in = CP_W'(item.data_byte[3:0]);
                  end
                  KIND_LEAD4: begin
                     seq_in  = 3'd4;
                     pend_in = 2'd3;
                     part_in = CP_W'(item.data_byte[2:0]);
                  end
                  default: begin
                     err_in = STATUS_INVALID;
                  end
               endcase
            end else if (item.byte_kind != KIND_CONT) begin
               // A bad continuation byte is not tried again as a lead byte.
               err_in  = STATUS_INVALID;
               pend_in = 2'd0;
            end else begin
               pend_in = pend_ff - 2'd1;
               part_in = shifted;
               if (pend_ff == 2'd1) begin
                  value   = shifted;
                  seq_in  = 3'd0;
                  part_in = '0;
                  if (shifted < minimum || shifted > CP_MAX ||
                      (shifted >= SURR_LOW && shifted <= SURR_HIGH)) begin
                     err_in = STATUS_INVALID;
                  end else begin
                     check = 1'b1;
                  end
               end
            end
            // C0 and C1 control code points end decoding.
            if (check) begin
               if (value <= C0_HIGH || (value >= C1_LOW && value <= C1_HIGH)) begin
                  err_in = STATUS_CONTROL;
               end else begin
                  got = 1'b1;
               end
            end
         end
      end
      if (item.last_byte) begin
         // A sequence cut short counts as invalid unless an error came first.
         if (err_in == STATUS_PROGRESS && pend_in != 2'd0) begin
            final_err = STATUS_INVALID;
         end else begin
            final_err = err_in;
         end
         if (count_in == '0) begin
            status = STATUS_EMPTY;
         end else if (count_in > COUNT_W'(max_id_bytes)) begin
            status = STATUS_TOO_LONG;
         end else if (final_err != STATUS_PROGRESS) begin
            status = final_err;
         end else begin
            status = STATUS_ACCEPTED;
         end
         count_in = '0;
         pend_in  = 2'd0;
         seq_in   = 3'd0;
         part_in  = '0;
         err_in   = STATUS_PROGRESS;
      end
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      char_in      = char_ff;
      done_in      = done_ff;
      cp_in        = cp_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         status_in    = status;
         char_in      = got;
         done_in      = item.last_byte;
         cp_in        = got ? value : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= '0;
         seq_ff       <= '0;
         part_ff      <= '0;
         err_ff       <= STATUS_PROGRESS;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            count_ff <= count_in;
            pend_ff  <= pend_in;
            seq_ff   <= seq_in;
            part_ff  <= part_in;
            err_ff   <= err_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      char_ff   <= char_in;
      done_ff   <= done_in;
      cp_ff     <= cp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cp_ff, status_ff};
   assign rsp_tlast  = done_ff;
   assign rsp_tuser  = char_ff;

endmodule

@@ tb/utf8_identifier_validator_top_tb.sv @@
// Self-checking testbench for the UTF-8 identifier validator: stimulus, prediction and checks.
module utf8_identifier_validator_top_tb;
   import uiv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_PERCENT  = 17;

   // One result transfer, split into its fields.
   typedef struct packed {
      logic                id_done;
      logic [STATUS_W-1:0] status;
      logic                char_done;
      logic [CP_W-1:0]     char_value;
   } verdict_type;

   typedef logic [DATA_W-1:0] byte_list_type[$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;   // [7:0] data_byte
   logic                  req_tlast = 1'b0; // last_byte
   logic                  req_tuser = 1'b0; // no_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [2:0] status, [23:3] char_value
   logic                  rsp_tlast;        // id_done
   logic                  rsp_tuser;        // char_done
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Mirror of the decoder state and the length limit.
   logic [COUNT_W-1:0]  id_len;
   logic [1:0]          cont_left;
   logic [2:0]          seq_bytes;
   logic [CP_W-1:0]     acc_value;
   logic [STATUS_W-1:0] id_err;
   logic [MAX_ID_W-1:0] len_limit;

   verdict_type   verdicts_due[$];
   byte_list_type id_bytes;
   int            fail_count = 0;
   int            results_seen = 0;
   int            items_sent = 0;
   int            hold_request = 0;
   int            cycle_count = 0;
   bit            no_idle = 1'b0;

   utf8_identifier_validator_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock.
   initial begin
      forever #4 clock = ~clock;
   end

   // Counts failures; only the first 10 are printed.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Clears the per-identifier state, as the block does at the end of an identifier.
   function automatic void clear_identifier();
      id_len    = '0;
      cont_left = '0;
      seq_bytes = '0;
      acc_value = '0;
      id_err    = STATUS_PROGRESS;
   endfunction

   // Advances the decoder state by one item and returns the result it must produce.
   function automatic verdict_type decode_and_judge(input logic [7:0] b, input logic last,
                                                    input logic none);
      verdict_type     v;
      logic [CP_W-1:0] cp;
      logic [CP_W-1:0] min_cp;
      logic            got;
      v   = '0;
      cp  = '0;
      got = 1'b0;
      if (!none) begin
         if (id_len < COUNT_MAX) begin
            id_len++;
         end
         // Once an error is recorded the remaining bytes are only counted.
         if (id_err == STATUS_PROGRESS) begin
            if (cont_left == 0) begin
               if (b[7] == 1'b0) begin
                  cp  = CP_W'(b);
                  got = 1'b1;
               end else if (b[7:5] == 3'b110) begin
                  seq_bytes = 3'd2;
                  cont_left = 2'd1;
                  acc_value = CP_W'(b[4:0]);
               end else if (b[7:4] == 4'b1110) begin
                  seq_bytes = 3'd3;
                  cont_left = 2'd2;
                  acc_value = CP_W'(b[3:0]);
               end else if (b[7:3] == 5'b11110) begin
                  seq_bytes = 3'd4;
                  cont_left = 2'd3;
                  acc_value = CP_W'(b[2:0]);
               end else begin
                  id_err = STATUS_INVALID;
               end
            end else if (b[7:6] != 2'b10) begin
               // A bad continuation byte is not retried as a lead byte.
               id_err    = STATUS_INVALID;
               cont_left = '0;
            end else begin
               acc_value = {acc_value[CP_W-7:0], b[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 0) begin
                  min_cp = (seq_bytes == 3'd2) ? MIN_TWO :
                           (seq_bytes == 3'd3) ? MIN_THREE : MIN_FOUR;
                  cp        = acc_value;
                  seq_bytes = '0;
                  acc_value = '0;
                  if (cp < min_cp || cp > CP_MAX || (cp >= SURR_LOW && cp <= SURR_HIGH)) begin
                     id_err = STATUS_INVALID;
                  end else begin
                     got = 1'b1;
                  end
               end
            end
            // C0 and C1 control code points are refused.
            if (got && (cp <= C0_HIGH || (cp >= C1_LOW && cp <= C1_HIGH))) begin
               id_err = STATUS_CONTROL;
               got    = 1'b0;
            end
         end
      end
      if (last) begin
         v.id_done = 1'b1;
         if (id_err == STATUS_PROGRESS && cont_left != 0) begin
            id_err = STATUS_INVALID;
         end
         if (id_len == 0) begin
            v.status = STATUS_EMPTY;
         end else if (id_len > COUNT_W'(len_limit)) begin
            v.status = STATUS_TOO_LONG;
         end else if (id_err != STATUS_PROGRESS) begin
            v.status = id_err;
         end else begin
            v.status = STATUS_ACCEPTED;
         end
         clear_identifier();
      end
      v.char_done  = got;
      v.char_value = got ? cp : '0;
      return v;
   endfunction

   // Offers one item, waits for its transfer and records the expected result.
   task automatic send_item(input logic [7:0] b, input logic last, input logic none);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= none;
      do @(posedge clock); while (!req_tready);
      verdicts_due.push_back(decode_and_judge(b, last, none));
      items_sent++;
   endtask

   // Sends one identifier; the end mark rides on the last byte or on a separate no-byte item.
   task automatic send_word(input byte_list_type word, input bit split_end);
      foreach (word[i]) begin
         if ($urandom_range(19) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
         end
         send_item(word[i], !split_end && (i == word.size() - 1), 1'b0);
      end
      if (split_end || word.size() == 0) begin
         send_item(8'($urandom), 1'b1, 1'b1);
      end
   endtask

   // Stops offering items until every expected result has arrived and the block is quiet.
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the length limit, then reads it back in a second transfer.
   task automatic write_limit(input logic [MAX_ID_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_MAX_ID_BYTES, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      len_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[MAX_ID_W-1:0] !== value) begin
         note_failure($sformatf("max_id_bytes read back %h, expected %h",
                                csr_prdata[MAX_ID_W-1:0], value));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Appends the encoding of a code point in the given number of bytes.
   function automatic void push_encoded(input logic [CP_W-1:0] cp, input int n);
      case (n)
         1: id_bytes.push_back(cp[7:0]);
         2: begin
            id_bytes.push_back({3'b110, cp[10:6]});
            id_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            id_bytes.push_back({4'b1110, cp[15:12]});
            id_bytes.push_back({2'b10, cp[11:6]});
            id_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            id_bytes.push_back({5'b11110, cp[20:18]});
            id_bytes.push_back({2'b10, cp[17:12]});
            id_bytes.push_back({2'b10, cp[11:6]});
            id_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // Appends one character; kinds below 72 are well formed, the rest are faults.
   function automatic void add_char(input int kind);
      logic [CP_W-1:0] cp;
      int              n;
      if (kind < 30) begin
         push_encoded(CP_W'($urandom_range(8'h7E, 8'h20)), 1);
      end else if (kind < 45) begin
         push_encoded(CP_W'($urandom_range(21'h7FF, 21'hA0)), 2);
      end else if (kind < 58) begin
         cp = CP_W'($urandom_range(21'hFFFF, 21'h800));
         if (cp >= SURR_LOW && cp <= SURR_HIGH) begin
            cp = cp ^ 21'h4000;
         end
         push_encoded(cp, 3);
      end else if (kind < 72) begin
         push_encoded(CP_W'($urandom_range(CP_MAX, MIN_FOUR)), 4);
      end else if (kind < 80) begin
         // Control code points: C0, DEL and C1.
         case ($urandom_range(2))
            0: push_encoded(CP_W'($urandom_range(C0_HIGH, 0)), 1);
            1: push_encoded(C1_LOW, 1);
            default: push_encoded(CP_W'($urandom_range(C1_HIGH, MIN_TWO)), 2);
         endcase
      end else if (kind < 84) begin
         // Overlong form: a value that fits in fewer bytes.
         n = $urandom_range(4, 2);
         cp = (n == 2) ? CP_W'($urandom_range(8'h7F)) :
              (n == 3) ? CP_W'($urandom_range(12'h7FF)) : CP_W'($urandom_range(16'hFFFF));
         push_encoded(cp, n);
      end else if (kind < 87) begin
         push_encoded(CP_W'($urandom_range(SURR_HIGH, SURR_LOW)), 3);
      end else if (kind < 90) begin
         push_encoded(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      end else if (kind < 94) begin
         // Sequence cut short by one or more continuation bytes.
         n = $urandom_range(4, 2);
         push_encoded(CP_W'($urandom_range(CP_MAX, MIN_FOUR)), n);
         repeat ($urandom_range(n - 1, 1)) void'(id_bytes.pop_back());
      end else begin
         id_bytes.push_back(8'($urandom));
      end
   endfunction

   // Builds and sends one random identifier.
   task automatic send_identifier(input bit messy, input int max_chars);
      int n_chars;
      n_chars = $urandom_range(max_chars, 0);
      id_bytes.delete();
      for (int k = 0; k < n_chars; k++) begin
         add_char(messy ? $urandom_range(99) : $urandom_range(71));
      end
      send_word(id_bytes, $urandom_range(7) == 0);
   endtask

   // Sends random identifiers, mostly well formed, until enough items have gone.
   task automatic run_identifiers(input int n_items);
      int start;
      start = items_sent;
      while (items_sent - start < n_items) begin
         send_identifier($urandom_range(9) < 3, ($urandom_range(9) == 0) ? 30 : 8);
      end
   endtask

   // Sends one long run of printable bytes ending in a last mark.
   task automatic send_long_identifier(input int n_bytes);
      for (int k = 0; k < n_bytes; k++) begin
         send_item(8'($urandom_range(8'h7E, 8'h20)), k == n_bytes - 1, 1'b0);
      end
   endtask

   // Empty identifiers, no-byte fillers and an end mark without a byte.
   task automatic test_empty_items();
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h41, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
   endtask

   // Well-formed sequences of every length, up to the largest code point.
   task automatic test_well_formed();
      send_word('{8'h41}, 1'b0);
      send_word('{8'hC2, 8'hA0, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
   endtask

   // One identifier for each kind of decode error.
   task automatic test_malformed();
      send_word('{8'hED, 8'hA0, 8'h80}, 1'b0);         // surrogate
      send_word('{8'hC3, 8'h41}, 1'b0);                // bad continuation
      send_word('{8'hE2, 8'h82}, 1'b0);                // truncated at the end
      send_word('{8'h7F}, 1'b0);                       // control code point
      send_word('{8'hFF}, 1'b0);                       // bad lead byte
      send_word('{8'hC0, 8'h80}, 1'b0);                // overlong
      send_word('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);  // above the largest code point
   endtask

   // Random identifiers at the reset limit, with and without idling.
   task automatic test_random_identifiers();
      run_identifiers(150);
      no_idle = 1'b1;
      run_identifiers(200);
      no_idle = 1'b0;
   endtask

   // Random identifiers under a range of limits, the extremes among them.
   task automatic test_length_limits();
      logic [MAX_ID_W-1:0] limits[6];
      limits = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'($urandom_range(40, 2)), 16'd4096};
      foreach (limits[p]) begin
         wait_all_results();
         write_limit(limits[p]);
         run_identifiers(110);
      end
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_back_pressure();
      wait_all_results();
      hold_request = 120;
      no_idle = 1'b1;
      run_identifiers(60);
      no_idle = 1'b0;
      wait_all_results();
   endtask

   // Identifiers exactly at the length limit and one byte past it.
   task automatic test_limit_boundary();
      wait_all_results();
      write_limit(16'd99);
      no_idle = 1'b1;
      send_long_identifier(99);
      send_long_identifier(100);
      no_idle = 1'b0;
   endtask

   // Receiver: random stalls, and long hold-offs on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      verdict_type seen;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tlast, rsp_tdata[2:0], rsp_tuser, rsp_tdata[23:3]};
         results_seen++;
         if (verdicts_due.size() == 0) begin
            note_failure($sformatf("result %0d arrived with none expected", results_seen));
         end else begin
            want = verdicts_due.pop_front();
            if (seen !== want) begin
               note_failure($sformatf(
                  "result %0d: expected done=%0d status=%0d char=%0d cp=%h, got %0d %0d %0d %h",
                  results_seen, want.id_done, want.status, want.char_done, want.char_value,
                  seen.id_done, seen.status, seen.char_done, seen.char_value));
            end
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL utf8_identifier_validator_top");
      $finish;
   end

   // Test sequence.
   initial begin
      len_limit = MAX_ID_BYTES_RESET;
      clear_identifier();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_items();
      test_well_formed();
      test_malformed();
      test_random_identifiers();
      test_length_limits();
      test_back_pressure();
      test_limit_boundary();
      wait_all_results();
      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("PASS utf8_identifier_validator_top");
      end else begin
         $display("FAIL utf8_identifier_validator_top");
      end
      $finish;
   end

endmodule
